### design/hkeg_pkg.sv
// hkeg_pkg: shared constants and types of the hid key event generator
// no dependencies; used by the interfaces, hkeg_evt_out and the top level
`default_nettype none

package hkeg_pkg;

  localparam int unsigned KEY_W            = 8;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned SLOT_FIELDS      = 6;
  localparam int unsigned KEY_CODES_DEF    = 256;
  localparam int unsigned REPORT_SLOTS_DEF = 6;

  // history bit positions
  localparam int unsigned CUR_POS  = 0;
  localparam int unsigned PREV_POS = 1;

  // event kinds
  localparam logic [KIND_W-1:0] EV_DOWN  = 2'd0;
  localparam logic [KIND_W-1:0] EV_PRESS = 2'd1;
  localparam logic [KIND_W-1:0] EV_UP    = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  code;
    logic [KIND_W-1:0] kind;
  } hkeg_evt_t;

  // scan engine to output stage
  typedef struct packed {
    logic      push;
    logic      flush;
    hkeg_evt_t evt;
  } hkeg_out_ctl_t;

  // output stage back to scan engine
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } hkeg_out_sts_t;

endpackage

`default_nettype wire

### design/hkeg_if.sv
// hkeg_if: valid/ready channels for keyboard reports and key events
// depends on hkeg_pkg for field widths
`default_nettype none

interface hkeg_report_if import hkeg_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_slot_a;
  logic [KEY_W-1:0] key_slot_b;
  logic [KEY_W-1:0] key_slot_c;
  logic [KEY_W-1:0] key_slot_d;
  logic [KEY_W-1:0] key_slot_e;
  logic [KEY_W-1:0] key_slot_f;
  logic             link_lost;

  modport source (
    output valid, key_slot_a, key_slot_b, key_slot_c, key_slot_d, key_slot_e,
           key_slot_f, link_lost,
    input  ready
  );
  modport sink (
    input  valid, key_slot_a, key_slot_b, key_slot_c, key_slot_d, key_slot_e,
           key_slot_f, link_lost,
    output ready
  );
endinterface

interface hkeg_event_if import hkeg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_code;
  logic [KIND_W-1:0] event_kind;
  logic              last_event;

  modport source (
    output valid, key_code, event_kind, last_event,
    input  ready
  );
  modport sink (
    input  valid, key_code, event_kind, last_event,
    output ready
  );
endinterface

`default_nettype wire

### design/hkeg_evt_out.sv
// hkeg_evt_out: event output stage, holds one event back until the next one
// or the end of the scan decides its last_event flag; depends on hkeg_pkg
`default_nettype none

module hkeg_evt_out import hkeg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hkeg_out_ctl_t ctl_i,
  output hkeg_out_sts_t sts_o,
  hkeg_event_if.source  event_o
);

  logic      pend_vld_q, pend_vld_d;
  hkeg_evt_t pend_q, pend_d;
  logic      out_vld_q, out_vld_d;
  hkeg_evt_t out_q, out_d;
  logic      out_last_q, out_last_d;
  logic      out_free;
  logic      push_fire;
  logic      flush_fire;

  assign out_free       = !out_vld_q || event_o.ready;
  assign sts_o.push_ok  = !pend_vld_q || out_free;
  assign sts_o.flush_ok = !pend_vld_q || out_free;
  assign push_fire      = ctl_i.push && sts_o.push_ok;
  assign flush_fire     = ctl_i.flush && sts_o.flush_ok;

  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !event_o.ready;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push_fire) begin
      // a newer event exists, so the held one is not the last
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = pend_q;
        out_last_d = 1'b0;
      end
      pend_vld_d = 1'b1;
      pend_d     = ctl_i.evt;
    end else if (flush_fire && pend_vld_q) begin
      out_vld_d  = 1'b1;
      out_d      = pend_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign event_o.valid      = out_vld_q;
  assign event_o.key_code   = out_q.code;
  assign event_o.event_kind = out_q.kind;
  assign event_o.last_event = out_last_q;

endmodule

`default_nettype wire

### design/hid_key_event_generator.sv
// hid_key_event_generator: per-report key down/press/up events from a 2-bit history RAM
// each key code's history entry is read in order, then evaluated and pushed to the output
// stage if it gives an event; an event shows once the next event or the end of the sweep fixes
// its last flag; a key that went down gives a down and then a press event; a new report is
// taken only in idle, after the sweep and the flush are done, and output stalls hold the sweep; a link-lost report
// clears the history and gives no events; async reset clears the valid bits
`default_nettype none

module hid_key_event_generator import hkeg_pkg::*; #(
  parameter int unsigned KEY_CODES    = KEY_CODES_DEF,
  parameter int unsigned REPORT_SLOTS = REPORT_SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hkeg_report_if.sink   report_i,
  hkeg_event_if.source  event_o
);

  localparam int unsigned IDX_W      = $clog2(KEY_CODES);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned USED_SLOTS =
    (REPORT_SLOTS > SLOT_FIELDS) ? SLOT_FIELDS : REPORT_SLOTS;
  localparam logic [CNT_W-1:0] END_CNT = CNT_W'(KEY_CODES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [KEY_W-1:0]     slot_in [SLOT_FIELDS];
  logic [KEY_W-1:0]     slots_q [USED_SLOTS];
  logic [KEY_CODES-1:0] valid_q;
  logic [1:0]           mem_q [KEY_CODES];
  logic [1:0]           rdata_q;
  logic [CNT_W-1:0]     rd_cnt_q;
  logic                 e_vld_q;
  logic [IDX_W-1:0]     e_idx_q;
  logic                 down_done_q;

  logic          acc;
  logic          issue_done;
  logic [1:0]    hist;
  logic [1:0]    new_hist;
  logic          hit;
  logic          prev;
  logic          has_ev;
  logic          more;
  logic          step;
  logic          consume;
  logic          re;
  logic          we;
  hkeg_out_ctl_t out_ctl;
  hkeg_out_sts_t out_sts;

  assign report_i.ready = (state_q == ST_IDLE);
  assign acc            = report_i.valid && report_i.ready;

  assign slot_in[0] = report_i.key_slot_a;
  assign slot_in[1] = report_i.key_slot_b;
  assign slot_in[2] = report_i.key_slot_c;
  assign slot_in[3] = report_i.key_slot_d;
  assign slot_in[4] = report_i.key_slot_e;
  assign slot_in[5] = report_i.key_slot_f;

  // entry under evaluation, unwritten entries read as released
  assign hist = valid_q[e_idx_q] ? rdata_q : 2'b00;
  assign prev = hist[CUR_POS];

  always_comb begin
    hit = 1'b0;
    for (int s = 0; s < USED_SLOTS; s++) begin
      if (slots_q[s] != '0 && slots_q[s] == KEY_W'(e_idx_q)) hit = 1'b1;
    end
  end

  assign new_hist = {prev, hit};
  assign has_ev   = hit || prev;
  assign more     = hit && !prev && !down_done_q;

  assign step    = e_vld_q && (!has_ev || out_sts.push_ok);
  assign consume = step && !more;

  always_comb begin
    out_ctl.push     = step && has_ev;
    out_ctl.flush    = (state_q == ST_FLUSH);
    out_ctl.evt.code = KEY_W'(e_idx_q);
    priority if (more) begin
      out_ctl.evt.kind = EV_DOWN;
    end else if (hit) begin
      out_ctl.evt.kind = EV_PRESS;
    end else begin
      out_ctl.evt.kind = EV_UP;
    end
  end

  assign issue_done = (rd_cnt_q == END_CNT);
  assign re         = (state_q == ST_SWEEP) && !issue_done && (!e_vld_q || consume);
  assign we         = consume;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && !report_i.link_lost) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (issue_done && !e_vld_q) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_sts.flush_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      rd_cnt_q    <= '0;
      e_vld_q     <= 1'b0;
      down_done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc && report_i.link_lost) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[e_idx_q] <= 1'b1;
      end
      if (acc) begin
        rd_cnt_q <= '0;
      end else if (re) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      if (re) begin
        e_vld_q <= 1'b1;
      end else if (consume) begin
        e_vld_q <= 1'b0;
      end
      if (consume) begin
        down_done_q <= 1'b0;
      end else if (step && more) begin
        down_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int s = 0; s < USED_SLOTS; s++) slots_q[s] <= slot_in[s];
    end
    if (re) e_idx_q <= rd_cnt_q[IDX_W-1:0];
  end

  // history RAM, one read and one write-back per cycle at different entries
  always_ff @(posedge clk_i) begin
    if (we) mem_q[e_idx_q] <= new_hist;
    if (re) rdata_q <= mem_q[rd_cnt_q[IDX_W-1:0]];
  end

  hkeg_evt_out u_evt_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (out_ctl),
    .sts_o   (out_sts),
    .event_o (event_o)
  );

endmodule

`default_nettype wire
